### rtl/lkcd_pkg.sv
// Shared types and constants for the LRU keyed cache directory.
// Used by lkcd_ctrl, lkcd_dpath and lru_keyed_cache_directory; no dependencies.
package lkcd_pkg;

  // Directory geometry
  localparam int ENTRIES  = 8;
  localparam int KEY_BITS = 64;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  // Fixed port field widths
  localparam int SLOT_W = 3;
  localparam int OCC_W  = 4;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Request transaction
  typedef struct packed {
    action_t     action;
    logic [63:0] key;
    logic [31:0] max_age;
    logic        age_given;
    logic [31:0] now;
  } in_item_t;

  // Response transaction
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [SLOT_W-1:0] evicted_slot;
    logic [31:0]       hit_max_age;
    logic              hit_age_given;
    logic [31:0]       hit_time;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the request
    logic exec;       // search and update directory state
    logic load_out;   // load the output register
    logic out_taken;  // output register drained this cycle
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_valid;
  } sts_t;

endpackage

### rtl/lkcd_ctrl.sv
// Sequencing controller for the LRU keyed cache directory.
// Depends on lkcd_pkg for the command and status structs.
module lkcd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_stall,
  input  lkcd_pkg::sts_t  sts,
  output lkcd_pkg::cmd_t  cmd
);
  import lkcd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_free;
  logic   accept;

  // Output register can take a new result this cycle
  assign out_free = !sts.out_valid || !out_stall;

  // Input ready in idle, or while the finished result moves out
  always_comb begin
    unique case (state_r)
      S_IDLE:   in_stall = 1'b0;
      S_SEARCH: in_stall = 1'b1;
      S_RESULT: in_stall = !out_free;
      default:  in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SEARCH;
      end
      S_SEARCH: state_nxt = S_RESULT;
      S_RESULT: begin
        if (out_free) state_nxt = accept ? S_SEARCH : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands
  assign cmd.capture   = accept;
  assign cmd.exec      = (state_r == S_SEARCH);
  assign cmd.load_out  = (state_r == S_RESULT) && out_free;
  assign cmd.out_taken = sts.out_valid && !out_stall;

  // A result is never loaded over one still waiting downstream
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(sts.out_valid && out_stall))
    else $error("output register overwritten while stalled");

endmodule

### rtl/lkcd_dpath.sv
// Datapath of the LRU keyed cache directory: key CAM, recency ranks,
// metadata RAM and output register. Depends on lkcd_pkg.
module lkcd_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  lkcd_pkg::in_item_t  in_data,
  input  lkcd_pkg::cmd_t      cmd,
  output lkcd_pkg::sts_t      sts,
  output lkcd_pkg::out_item_t out_data
);
  import lkcd_pkg::*;

  localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic [31:0] max_age;
    logic        age_given;
    logic [31:0] now;
  } meta_t;

  // Request and directory state
  in_item_t             req_r;
  logic [ENTRIES-1:0]   valid_r, valid_nxt;
  logic [KEY_BITS-1:0]  key_r [ENTRIES];
  logic [IDX_W-1:0]     rank_r [ENTRIES];
  logic [IDX_W-1:0]     rank_nxt [ENTRIES];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  meta_t                meta_mem [ENTRIES];
  meta_t                meta_rd_r;

  // Search results held for the response
  logic                 res_hit_r;
  logic [IDX_W-1:0]     res_slot_r;
  logic                 res_ev_r;
  logic [IDX_W-1:0]     res_ev_slot_r;
  logic [CNT_W-1:0]     res_occ_r;
  logic                 res_meta_r;

  logic                 out_valid_r;
  out_item_t            out_data_r, out_nxt;

  // Search
  logic [ENTRIES-1:0]   match;
  logic                 hit_any, free_any;
  logic [IDX_W-1:0]     hit_idx, free_idx, evict_idx, tgt_idx, hit_rank;
  logic                 is_insert, is_lookup, is_remove;

  assign is_lookup = (req_r.action == ACT_LOOKUP);
  assign is_insert = (req_r.action == ACT_INSERT);
  assign is_remove = (req_r.action == ACT_REMOVE);

  // Parallel key compare and lowest-index priority picks
  always_comb begin
    hit_idx   = '0;
    free_idx  = '0;
    evict_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == req_r.key[KEY_BITS-1:0]);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = IDX_W'(i);
      if (!valid_r[i]) free_idx = IDX_W'(i);
      if (valid_r[i] && rank_r[i] == RANK_MAX) evict_idx = IDX_W'(i);
    end
    hit_any  = |match;
    free_any = ~&valid_r;
    hit_rank = rank_r[hit_idx];
    tgt_idx  = free_any ? free_idx : evict_idx;
  end

  // Next directory state
  always_comb begin
    logic [CNT_W-1:0] cnt_tmp;
    logic             keep;
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    cnt_tmp   = cnt_r;
    keep      = 1'b0;
    unique case (req_r.action)
      ACT_LOOKUP: begin
        if (hit_any) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i] && rank_r[i] < hit_rank) rank_nxt[i] = rank_r[i] + 1'b1;
          end
          rank_nxt[hit_idx] = '0;
        end
      end
      ACT_INSERT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          keep = valid_r[i] && !(!free_any && IDX_W'(i) == evict_idx);
          if (keep && rank_r[i] < RANK_MAX) rank_nxt[i] = rank_r[i] + 1'b1;
        end
        valid_nxt[tgt_idx] = 1'b1;
        rank_nxt[tgt_idx]  = '0;
        if (!free_any && cnt_tmp != '0) cnt_tmp = cnt_tmp - 1'b1;
        if (cnt_tmp < CNT_W'(ENTRIES)) cnt_tmp = cnt_tmp + 1'b1;
      end
      ACT_REMOVE: begin
        if (hit_any) begin
          valid_nxt[hit_idx] = 1'b0;
          rank_nxt[hit_idx]  = '0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_nxt[i] && rank_r[i] > hit_rank) rank_nxt[i] = rank_r[i] - 1'b1;
          end
          if (cnt_tmp != '0) cnt_tmp = cnt_tmp - 1'b1;
        end
      end
      ACT_NONE: ;
      default: ;
    endcase
    cnt_nxt = cnt_tmp;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      rank_r      <= '{default: '0};
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        valid_r <= valid_nxt;
        rank_r  <= rank_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (cmd.out_taken) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request, keys and search results
  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_data;
    if (cmd.exec) begin
      if (is_insert) key_r[tgt_idx] <= req_r.key[KEY_BITS-1:0];
      res_hit_r     <= (is_lookup || is_remove) && hit_any;
      res_slot_r    <= is_insert ? tgt_idx :
                       ((is_lookup || is_remove) && hit_any) ? hit_idx : '0;
      res_ev_r      <= is_insert && !free_any;
      res_ev_slot_r <= (is_insert && !free_any) ? evict_idx : '0;
      res_occ_r     <= cnt_nxt;
      res_meta_r    <= is_lookup && hit_any;
    end
  end

  // Metadata RAM: write on insert, registered read of the matched slot
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (is_insert) begin
        meta_mem[tgt_idx] <= '{max_age:   req_r.max_age,
                               age_given: req_r.age_given,
                               now:       req_r.now};
      end
      meta_rd_r <= meta_mem[hit_idx];
    end
  end

  // Response assembly
  always_comb begin
    out_nxt.hit           = res_hit_r;
    out_nxt.slot          = SLOT_W'(res_slot_r);
    out_nxt.evicted       = res_ev_r;
    out_nxt.evicted_slot  = SLOT_W'(res_ev_slot_r);
    out_nxt.hit_max_age   = res_meta_r ? meta_rd_r.max_age : 32'd0;
    out_nxt.hit_age_given = res_meta_r ? meta_rd_r.age_given : 1'b0;
    out_nxt.hit_time      = res_meta_r ? meta_rd_r.now : 32'd0;
    out_nxt.occupancy     = OCC_W'(res_occ_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_data_r <= out_nxt;
  end

  assign out_data      = out_data_r;
  assign sts.out_valid = out_valid_r;

  // Occupancy tracks the valid bits
  a_cnt_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(valid_r)))
    else $error("occupancy count differs from valid bits");

  // A full directory always holds a least recent valid slot
  a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && is_insert && !free_any) |->
      (valid_r[evict_idx] && rank_r[evict_idx] == RANK_MAX))
    else $error("no least recent slot found on a full directory");

  // Lookup leaves occupancy untouched
  a_lookup_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && is_lookup) |=> (cnt_r == $past(cnt_r)))
    else $error("lookup changed occupancy");

endmodule

### rtl/lru_keyed_cache_directory.sv
// Fully associative LRU cache directory of eight slots with per-slot key
// compare; a request transaction is accepted and captured, searched by key with the
// directory updated in the search state, and its response is loaded into the output
// register in the result state, when the next request may already be accepted if the
// output register is free. The input stalls in the search state, so a new request is
// not taken until the previous one reaches the result state. Valid bits, ranks and
// occupancy clear at reset with no clearing pass; slot data lives outside, addressed by
// the returned slot. Depends on lkcd_pkg, lkcd_ctrl and lkcd_dpath.
module lru_keyed_cache_directory (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lkcd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lkcd_pkg::out_item_t out_data
);
  import lkcd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lkcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lkcd_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  assign out_valid = sts.out_valid;

endmodule

### bench/lkcd_directory_check.sv
// Directory shadow for the LRU keyed cache directory: mirrors slot state, works out each reply
// and compares every accepted reply field by field. Depends on lkcd_pkg.
module lkcd_directory_check
  import lkcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        pending,
  output int        fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] KEY_MASK = (KEY_BITS >= 64) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);
  localparam int PRINT_CAP = 40;

  // Shadow of the directory
  logic             shadow_valid [ENTRIES];
  logic [63:0]      shadow_key   [ENTRIES];
  logic [31:0]      shadow_age   [ENTRIES];
  logic             shadow_has   [ENTRIES];
  logic [31:0]      shadow_time  [ENTRIES];
  logic [IDX_W-1:0] shadow_rank  [ENTRIES];
  logic [CNT_W-1:0] shadow_count;

  out_item_t pending_replies [$];
  int        errors     = 0;
  int        reply_no   = 0;

  // Lowest valid slot holding the key, -1 if none
  function automatic int lowest_match(input logic [63:0] k);
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_key[i] == k) return i;
    end
    return -1;
  endfunction

  // Apply one request to the shadow and work out the reply it should give
  task automatic update_directory(input in_item_t req, output out_item_t reply);
    int          s;
    int          r;
    int          best;
    int          i;
    logic [63:0] k;
    reply = '0;
    k = req.key & KEY_MASK;
    case (req.action)
      ACT_LOOKUP: begin
        s = lowest_match(k);
        if (s >= 0) begin
          r = int'(shadow_rank[s]);
          for (i = 0; i < ENTRIES; i++) begin
            if (shadow_valid[i] && shadow_rank[i] < r) shadow_rank[i] = shadow_rank[i] + 1'b1;
          end
          shadow_rank[s]      = '0;
          reply.hit           = 1'b1;
          reply.slot          = s[SLOT_W-1:0];
          reply.hit_max_age   = shadow_age[s];
          reply.hit_age_given = shadow_has[s];
          reply.hit_time      = shadow_time[s];
        end
      end
      ACT_INSERT: begin
        s = -1;
        for (i = 0; i < ENTRIES; i++) begin
          if (!shadow_valid[i] && s < 0) s = i;
        end
        // full: the oldest slot goes
        if (s < 0) begin
          best = 0;
          s    = 0;
          for (i = 0; i < ENTRIES; i++) begin
            if (shadow_rank[i] > best) begin
              best = int'(shadow_rank[i]);
              s    = i;
            end
          end
          shadow_valid[s] = 1'b0;
          if (shadow_count > 0) shadow_count = shadow_count - 1'b1;
          reply.evicted      = 1'b1;
          reply.evicted_slot = s[SLOT_W-1:0];
        end
        for (i = 0; i < ENTRIES; i++) begin
          if (shadow_valid[i] && shadow_rank[i] < ENTRIES - 1)
            shadow_rank[i] = shadow_rank[i] + 1'b1;
        end
        shadow_valid[s] = 1'b1;
        shadow_key[s]   = k;
        shadow_age[s]   = req.max_age;
        shadow_has[s]   = req.age_given;
        shadow_time[s]  = req.now;
        shadow_rank[s]  = '0;
        if (shadow_count < ENTRIES) shadow_count = shadow_count + 1'b1;
        reply.slot = s[SLOT_W-1:0];
      end
      ACT_REMOVE: begin
        s = lowest_match(k);
        if (s >= 0) begin
          r = int'(shadow_rank[s]);
          shadow_valid[s] = 1'b0;
          shadow_rank[s]  = '0;
          // close the gap left in the ranking
          for (i = 0; i < ENTRIES; i++) begin
            if (shadow_valid[i] && shadow_rank[i] > r) shadow_rank[i] = shadow_rank[i] - 1'b1;
          end
          if (shadow_count > 0) shadow_count = shadow_count - 1'b1;
          reply.hit  = 1'b1;
          reply.slot = s[SLOT_W-1:0];
        end
      end
      default: ;
    endcase
    reply.occupancy = OCC_W'(shadow_count);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < PRINT_CAP)
      $display("%0t ns: reply %0d: %s is %0h, expected %0h", $realtime, reply_no, field, got,
               want);
    errors++;
  endtask

  task automatic compare_reply(input out_item_t want, input out_item_t got);
    if (got.hit !== want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
    if (got.slot !== want.slot) report_mismatch("slot", 64'(got.slot), 64'(want.slot));
    if (got.evicted !== want.evicted)
      report_mismatch("evicted", 64'(got.evicted), 64'(want.evicted));
    if (got.evicted_slot !== want.evicted_slot)
      report_mismatch("evicted_slot", 64'(got.evicted_slot), 64'(want.evicted_slot));
    if (got.hit_max_age !== want.hit_max_age)
      report_mismatch("hit_max_age", 64'(got.hit_max_age), 64'(want.hit_max_age));
    if (got.hit_age_given !== want.hit_age_given)
      report_mismatch("hit_age_given", 64'(got.hit_age_given), 64'(want.hit_age_given));
    if (got.hit_time !== want.hit_time)
      report_mismatch("hit_time", 64'(got.hit_time), 64'(want.hit_time));
    if (got.occupancy !== want.occupancy)
      report_mismatch("occupancy", 64'(got.occupancy), 64'(want.occupancy));
  endtask

  // Watch both channels; replies are checked before the new request is pushed
  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t predicted;
    int        i;
    if (!rst_n) begin
      for (i = 0; i < ENTRIES; i++) begin
        shadow_valid[i] = 1'b0;
        shadow_key[i]   = '0;
        shadow_age[i]   = '0;
        shadow_has[i]   = 1'b0;
        shadow_time[i]  = '0;
        shadow_rank[i]  = '0;
      end
      shadow_count = '0;
      pending_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("unexpected reply, slot", 64'(out_data.slot), 64'd0);
        end else begin
          want = pending_replies.pop_front();
          compare_reply(want, out_data);
        end
        reply_no++;
      end
      if (in_valid && !in_stall) begin
        update_directory(in_data, predicted);
        pending_replies.push_back(predicted);
      end
    end
    pending    <= pending_replies.size();
    fail_count <= errors;
  end

endmodule

### bench/tb_lru_keyed_cache_directory.sv
// Top of the LRU keyed cache directory bench: clock, reset, request and stall stimulus,
// watchdog and verdict. Depends on lkcd_pkg, lru_keyed_cache_directory, lkcd_directory_check.
module tb_lru_keyed_cache_directory;
  timeunit 1ns;
  timeprecision 1ps;
  import lkcd_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int PER_PHASE    = 306;
  localparam int POOL_SIZE    = 10;
  localparam int TAIL_CYCLES  = 10;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  int        pending;
  int        fail_count;

  int          idle_pct     = 0;
  int          stall_pct    = 0;
  int          quiet_cycles = 0;
  logic [63:0] key_pool [POOL_SIZE];

  lru_keyed_cache_directory dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  lkcd_directory_check reply_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .pending   (pending),
    .fail_count(fail_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** lru_keyed_cache_directory: FAILED **");
      $finish;
    end
  end

  function automatic in_item_t make_req(input action_t act, input logic [63:0] k,
                                        input logic [31:0] age, input logic has,
                                        input logic [31:0] stamp);
    in_item_t r;
    r.action    = act;
    r.key       = k;
    r.max_age   = age;
    r.age_given = has;
    r.now       = stamp;
    return r;
  endfunction

  function automatic logic [31:0] edgy_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly keys from a small, slowly changing pool so lookups and removes hit
  function automatic in_item_t random_request();
    int          pick;
    action_t     act;
    logic [63:0] k;
    if ($urandom_range(99) < 4) key_pool[$urandom_range(POOL_SIZE - 1)] = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 38)      act = ACT_LOOKUP;
    else if (pick < 72) act = ACT_INSERT;
    else if (pick < 95) act = ACT_REMOVE;
    else                act = ACT_NONE;
    if ($urandom_range(9) == 0) k = {$urandom, $urandom};
    else k = key_pool[$urandom_range(POOL_SIZE - 1)];
    return make_req(act, k, edgy_word(), 1'($urandom_range(1)), edgy_word());
  endfunction

  // Present one request and hold it until accepted
  task automatic send_request(input in_item_t req);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    int phase;
    int n;
    for (n = 0; n < POOL_SIZE; n++) key_pool[n] = {$urandom, $urandom};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty misses, extremes, duplicates, fill, evictions, removes
    send_request(make_req(ACT_LOOKUP, 64'h0123_4567_89AB_CDEF, '0, 1'b0, '0));
    send_request(make_req(ACT_REMOVE, 64'h0123_4567_89AB_CDEF, '0, 1'b0, '0));
    send_request(make_req(ACT_NONE,   '1, '1, 1'b1, '1));
    send_request(make_req(ACT_INSERT, '0, '0, 1'b0, '0));
    send_request(make_req(ACT_INSERT, '1, '1, 1'b1, '1));
    send_request(make_req(ACT_LOOKUP, '0, '1, 1'b1, '1));
    send_request(make_req(ACT_LOOKUP, '1, '0, 1'b0, '0));
    send_request(make_req(ACT_INSERT, '1, 32'd5, 1'b1, 32'd7));
    send_request(make_req(ACT_LOOKUP, '1, '0, 1'b0, '0));
    send_request(make_req(ACT_REMOVE, '1, '0, 1'b0, '0));
    send_request(make_req(ACT_LOOKUP, '1, '0, 1'b0, '0));
    send_request(make_req(ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 1'b1, 32'h10));
    send_request(make_req(ACT_INSERT, 64'h5555_5555_5555_5555, 32'h5555_5555, 1'b0, 32'h11));
    send_request(make_req(ACT_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b1, 32'h12));
    send_request(make_req(ACT_INSERT, 64'h0000_0000_0000_0001, 32'h1, 1'b0, 32'h13));
    send_request(make_req(ACT_INSERT, 64'hFFFF_FFFF_0000_0000, 32'hFFFF, 1'b1, 32'h14));
    send_request(make_req(ACT_INSERT, 64'h0000_0000_FFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h15));
    send_request(make_req(ACT_LOOKUP, '0, '0, 1'b0, '0));
    send_request(make_req(ACT_INSERT, 64'h1357_9BDF_0246_8ACE, 32'h20, 1'b1, 32'h16));
    send_request(make_req(ACT_INSERT, 64'hFEDC_BA98_7654_3210, 32'h21, 1'b0, 32'h17));
    send_request(make_req(ACT_REMOVE, 64'hDEAD_BEEF_DEAD_BEEF, '0, 1'b0, '0));
    send_request(make_req(ACT_NONE,   '0, '0, 1'b0, '0));
    send_request(make_req(ACT_LOOKUP, 64'hDEAD_BEEF_DEAD_BEEF, '0, 1'b0, '0));
    send_request(make_req(ACT_REMOVE, '0, '0, 1'b0, '0));
    send_request(make_req(ACT_INSERT, 64'h0F0F_0F0F_0F0F_0F0F, '1, 1'b1, '1));

    // Random: no idling, sender idle, receiver stalling, both
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 61; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      for (n = 0; n < PER_PHASE; n++) send_request(random_request());
    end
    in_valid <= 1'b0;

    // Drain outstanding replies, then allow for stray ones
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** lru_keyed_cache_directory: PASSED **");
    end else begin
      $display("** lru_keyed_cache_directory: FAILED **");
    end
    $finish;
  end

endmodule
